// ----- rtl/core/rkf_pkg.sv -----
package rkf_pkg;

	localparam int PIX_W       = 8;
	localparam int MODE_W      = 2;
	localparam int WIDTH_REG_W = 11;
	localparam int HEIGHT_W    = 16;
	localparam int MIN_DIM     = 3;
	localparam int MAX_WIDTH_DEF = 1024;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MED = 2'd2;

	localparam logic [MODE_W-1:0]      MODE_RST   = MODE_MED;
	localparam logic [WIDTH_REG_W-1:0] WIDTH_RST  = 11'd512;
	localparam logic [HEIGHT_W-1:0]    HEIGHT_RST = 16'd512;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t lo;
		pix_t mid;
		pix_t hi;
	} trio_t;

	typedef struct packed {
		logic row_end;
		logic frame_end;
	} tag_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		return min2(min2(a, b), c);
	endfunction

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		return max2(max2(a, b), c);
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// sorts its inputs into lo, mid and hi with min3, max3 and med3
	function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
		trio_t t;
		t.lo  = min3(a, b, c);
		t.hi  = max3(a, b, c);
		t.mid = med3(a, b, c);
		return t;
	endfunction

endpackage

// ----- rtl/core/rank_filter_3x3.sv -----
// Channel   Direction  Handshake                    Beat contents
// pixel     in         pixel_valid / pixel_stall    pixel, start_of_frame
// result    out        result_valid / result_stall  filtered, row_end, frame_end
// apb       in         psel / penable / pready      mode, image_width, image_height
//
// One pixel beat per clock while pixel_stall is low; at most one line store
// read and one write a cycle. A pixel that completes a window is read from the
// line store into stage 1, then sorted and selected into the output register.
// Reset clears counters, window and valids, presets config, not line stores.
// A stalled result holds stage 1 only while it carries an interior pixel;
// a border pixel in stage 1 leaves at once and never waits on result_stall.
module rank_filter_3x3 #(
	parameter int MAX_WIDTH = rkf_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rkf_pkg::PADDR_W-1:0]   paddr,
	input  logic [rkf_pkg::PDATA_W-1:0]   pwdata,
	output logic [rkf_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,

	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  rkf_pkg::pix_t                 pixel,
	input  logic                          start_of_frame,

	output logic                          result_valid,
	input  logic                          result_stall,
	output rkf_pkg::pix_t                 filtered,
	output logic                          row_end,
	output logic                          frame_end
);
	import rkf_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
	localparam int WCMP_W = (WEFF_W > WIDTH_REG_W) ? WEFF_W : WIDTH_REG_W;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [MODE_W-1:0]      mode_q;
	logic [WIDTH_REG_W-1:0] width_q;
	logic [HEIGHT_W-1:0]    height_q;
	logic                   cfg_wr;
	logic [1:0]             reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MODE:   mode_q   <= pwdata[MODE_W-1:0];
				REG_WIDTH:  width_q  <= pwdata[WIDTH_REG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[HEIGHT_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:   prdata = PDATA_W'(mode_q);
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	// Effective frame size: width clamped into 3..MAX_WIDTH, height raised to 3.
	logic [WCMP_W-1:0]   width_x;
	logic [WEFF_W-1:0]   w_eff;
	logic [HEIGHT_W-1:0] h_eff;

	assign width_x = WCMP_W'(width_q);

	always_comb begin
		if (width_x < WCMP_W'(MIN_DIM)) begin
			w_eff = WEFF_W'(MIN_DIM);
		end else if (width_x > WCMP_W'(MAX_WIDTH)) begin
			w_eff = WEFF_W'(MAX_WIDTH);
		end else begin
			w_eff = WEFF_W'(width_x);
		end
		h_eff = (height_q < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : height_q;
	end

	// ---------------------------------------------------------------
	// Pipeline handshake
	// ---------------------------------------------------------------
	logic v_s1, res_valid_q;
	logic int_s1;
	logic out_free, s1_pass, s1_free, accept;

	assign out_free    = !res_valid_q || !result_stall;
	// border pixels leave s1 without a slot downstream
	assign s1_pass     = v_s1 && (!int_s1 || out_free);
	assign s1_free     = !v_s1 || s1_pass;
	assign pixel_stall = !s1_free;
	assign accept      = pixel_valid && s1_free;

	// ---------------------------------------------------------------
	// Position counters
	// ---------------------------------------------------------------
	logic [COL_W-1:0]    col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [COL_W-1:0]    col_base, c_cur;
	logic [HEIGHT_W-1:0] row_base, r_cur;
	logic [HEIGHT_W:0]   r_inc, r_plus;
	logic [WEFF_W-1:0]   c_plus;
	logic                wrap, last_col, last_row, interior;

	always_comb begin
		col_base = start_of_frame ? '0 : col_q;
		row_base = start_of_frame ? '0 : row_q;
		// counter past a shrunken width: take as column 0 of the next row
		wrap     = WEFF_W'(col_base) >= w_eff;
		c_cur    = wrap ? '0 : col_base;
		r_inc    = wrap ? ({1'b0, row_base} + (HEIGHT_W+1)'(1)) : {1'b0, row_base};
		r_cur    = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[HEIGHT_W-1:0];
		c_plus   = WEFF_W'(c_cur) + WEFF_W'(1);
		r_plus   = {1'b0, r_cur} + (HEIGHT_W+1)'(1);
		last_col = c_plus >= w_eff;
		last_row = r_plus >= {1'b0, h_eff};
		interior = (r_cur >= HEIGHT_W'(2)) && (c_cur >= COL_W'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : r_plus[HEIGHT_W-1:0];
			end else begin
				col_q <= c_plus[COL_W-1:0];
				row_q <= r_cur;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: line store read, window shift, line store write
	// ---------------------------------------------------------------
	pix_t             px_s1;
	logic [COL_W-1:0] c_s1;
	tag_t             tag_s1;
	logic             byp_s1;
	pix_t             fwd_up_s1, fwd_mid_s1;
	pix_t             up_rd, mid_rd, up_eff, mid_eff;

	rkf_line_ram #(
		.DEPTH (MAX_WIDTH)
	) u_upper (
		.clk   (clk),
		.we    (s1_pass),
		.waddr (c_s1),
		.wdata (mid_eff),
		.re    (accept),
		.raddr (c_cur),
		.rdata (up_rd)
	);

	rkf_line_ram #(
		.DEPTH (MAX_WIDTH)
	) u_middle (
		.clk   (clk),
		.we    (s1_pass),
		.waddr (c_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (c_cur),
		.rdata (mid_rd)
	);

	// A restart of the frame can read the column that s1 writes at the same
	// edge; forward the written values in that case.
	assign up_eff  = byp_s1 ? fwd_up_s1  : up_rd;
	assign mid_eff = byp_s1 ? fwd_mid_s1 : mid_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			byp_s1 <= 1'b0;
			int_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= accept;
			if (accept) begin
				byp_s1 <= s1_pass && (c_cur == c_s1);
				int_s1 <= interior;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1            <= pixel;
			c_s1             <= c_cur;
			tag_s1.row_end   <= last_col;
			tag_s1.frame_end <= last_col && last_row;
			fwd_up_s1        <= mid_eff;
			fwd_mid_s1       <= px_s1;
		end
	end

	// window: [0..2] column c-2, [3..5] column c-1, top to bottom
	pix_t win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_pass) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up_eff;
			win_q[4] <= mid_eff;
			win_q[5] <= px_s1;
		end
	end

	// ---------------------------------------------------------------
	// Sort each column of three, then select min, max or median of nine;
	// the median is the median of (max of lows, median of mids, min of highs)
	// ---------------------------------------------------------------
	trio_t col_a, col_b, col_c;
	pix_t  min9, max9, lo_max, mid_med, hi_min;
	pix_t  rank_sel;

	always_comb begin
		col_a   = sort3(win_q[0], win_q[1], win_q[2]);
		col_b   = sort3(win_q[3], win_q[4], win_q[5]);
		col_c   = sort3(up_eff, mid_eff, px_s1);
		min9    = min3(col_a.lo, col_b.lo, col_c.lo);
		lo_max  = max3(col_a.lo, col_b.lo, col_c.lo);
		mid_med = med3(col_a.mid, col_b.mid, col_c.mid);
		hi_min  = min3(col_a.hi, col_b.hi, col_c.hi);
		max9    = max3(col_a.hi, col_b.hi, col_c.hi);
		case (mode_q)
			MODE_MIN: rank_sel = min9;
			MODE_MAX: rank_sel = max9;
			default:  rank_sel = med3(lo_max, mid_med, hi_min);
		endcase
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	pix_t filt_q;
	tag_t tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= s1_pass && int_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			filt_q <= rank_sel;
			tag_q  <= tag_s1;
		end
	end

	assign result_valid = res_valid_q;
	assign filtered     = filt_q;
	assign row_end      = tag_q.row_end;
	assign frame_end    = tag_q.frame_end;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !pixel_stall)
		else $error("pixel_stall raised with stage 1 empty");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted pixel beat missing from stage 1");

	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!frame_end || row_end))
		else $error("frame_end without row_end");

	a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall && v_s1 && int_s1) |-> pixel_stall)
		else $error("pixel beat taken with full pipe");

endmodule

// ----- rtl/core/rkf_line_ram.sv -----
module rkf_line_ram #(
	parameter int DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  rkf_pkg::pix_t              wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output rkf_pkg::pix_t              rdata
);
	import rkf_pkg::*;

	pix_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
